/* hw/rtl/lac_pkg.sv */
// ----------------------------------------------------------------------------
// lac_pkg: shared types and constants of the layer alpha compositor
// Pixel beat formats, APB register map and divider lane layout.
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int LANES   = 4;   // red, green, blue, alpha
    localparam int CH_W    = 8;
    localparam int CH_ALPHA = 3;
    localparam int Q_W     = 8;   // quotient bits = number of divider cells
    localparam int W_W     = 17;  // weight width (510*a fits)
    localparam int DEN_W   = 18;  // divisor width
    localparam int PROD_W  = 25;  // 17x8 product
    localparam int REM_W   = 25;  // numerator never exceeds 255*130050
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int FOCUS_W = 17;

    localparam logic [FOCUS_W-1:0] FOCUS_NONE = '1;  // -1
    localparam logic [DEN_W-1:0]   DIV_FLAT   = DEN_W'(255);
    localparam logic [DEN_W-1:0]   DIV_ALPHA  = DEN_W'(510);
    localparam logic [DEN_W-1:0]   DIV_ONE    = DEN_W'(1);
    localparam logic [CH_W-1:0]    CH_MAX     = 8'hFF;

    // register index = paddr[2]
    localparam logic REG_DIM_ENABLE = 1'b0;
    localparam logic REG_FOCUS      = 1'b1;

    // action field of an input beat
    localparam logic ACT_UNDER   = 1'b0;
    localparam logic ACT_FLATTEN = 1'b1;

    typedef struct packed {
        logic              action;
        logic [15:0]       layer_id;
        logic [CH_W-1:0]   cur_red;
        logic [CH_W-1:0]   cur_green;
        logic [CH_W-1:0]   cur_blue;
        logic [CH_W-1:0]   cur_alpha;
        logic [CH_W-1:0]   src_red;
        logic [CH_W-1:0]   src_green;
        logic [CH_W-1:0]   src_blue;
        logic [CH_W-1:0]   src_alpha;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } t_out_item;

    typedef struct packed {
        logic                      dim_enable;
        logic signed [FOCUS_W-1:0] focus_layer_id;
    } t_cfg;

    typedef enum logic [1:0] {
        MODE_PASS,   // canvas opaque: keep it
        MODE_COPY,   // canvas transparent: take the source
        MODE_BLEND,  // layer under canvas
        MODE_FLAT    // canvas over background
    } t_mode;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dv;
        logic [Q_W-1:0]   q;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lanes;

endpackage

/* hw/rtl/lac_cfg.sv */
// ----------------------------------------------------------------------------
// lac_cfg: APB register file
// Holds the dim enable bit and the focused layer id.
// ----------------------------------------------------------------------------
module lac_cfg import lac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic               r_dim_enable;
    logic [FOCUS_W-1:0] r_focus;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_enable <= 1'b0;
            r_focus      <= FOCUS_NONE;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_DIM_ENABLE: r_dim_enable <= pwdata[0];
                REG_FOCUS:      r_focus      <= pwdata[FOCUS_W-1:0];
                default:        r_focus      <= r_focus;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DIM_ENABLE: prdata = {{(DATA_W-1){1'b0}}, r_dim_enable};
            REG_FOCUS:      prdata = {{(DATA_W-FOCUS_W){r_focus[FOCUS_W-1]}}, r_focus};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.dim_enable     = r_dim_enable;
    assign o_cfg.focus_layer_id = $signed(r_focus);

    a_focus_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && paddr[2] == REG_FOCUS) |=> (r_focus == $past(pwdata[FOCUS_W-1:0])))
        else $error("focus register lost a write");

endmodule

/* hw/rtl/lac_front.sv */
// ----------------------------------------------------------------------------
// lac_front: classify, weight and multiply
// Three stages that turn a pixel beat into four numerator/divisor lanes
// for the divider chain. Copy and pass cases divide by one.
// ----------------------------------------------------------------------------
module lac_front import lac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_lanes   o_data
);

    // stage A: decode + layer weight multiply
    logic                            r_a_valid;
    t_mode                           r_a_mode;
    logic                            r_a_half;
    logic                            r_a_dimmed;
    logic [CH_W-1:0]                 r_a_alpha;
    logic [2*CH_W-1:0]               r_a_wl;
    logic [LANES-1:0][CH_W-1:0]      r_a_cur;
    logic [LANES-1:0][CH_W-1:0]      r_a_src;

    t_mode                           n_a_mode;
    logic                            w_dimmed;
    logic [CH_W-1:0]                 w_inv;
    logic [LANES-1:0][CH_W-1:0]      w_cur;
    logic [LANES-1:0][CH_W-1:0]      w_src;

    // stage B: products
    logic                            r_b_valid;
    logic [LANES-1:0][PROD_W-1:0]    r_b_p1;
    logic [LANES-1:0][PROD_W-1:0]    r_b_p2;
    logic [LANES-1:0][DEN_W-1:0]     r_b_dv;

    logic [W_W-1:0]                  w_wc;
    logic [W_W-1:0]                  w_wl;
    logic [DEN_W-1:0]                w_den;
    logic [CH_W-1:0]                 w_b_inv;
    logic [LANES-1:0][W_W-1:0]       w_w1;
    logic [LANES-1:0][W_W-1:0]       w_w2;
    logic [LANES-1:0][CH_W-1:0]      w_x1;
    logic [LANES-1:0][CH_W-1:0]      w_x2;
    logic [LANES-1:0][DEN_W-1:0]     n_b_dv;

    // stage C: sum, divisor aligned to quotient MSB
    logic                            r_c_valid;
    t_lanes                          r_c_data;
    t_lanes                          n_c_data;
    logic [LANES-1:0][PROD_W:0]      w_sum;

    logic w_a_ready;
    logic w_b_ready;
    logic w_c_ready;

    assign w_c_ready = !r_c_valid || i_ready;
    assign w_b_ready = !r_b_valid || w_c_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    // ---- stage A ----
    assign w_cur = {i_data.cur_alpha, i_data.cur_blue, i_data.cur_green, i_data.cur_red};
    assign w_src = {i_data.src_alpha, i_data.src_blue, i_data.src_green, i_data.src_red};
    assign w_inv = CH_MAX - i_data.cur_alpha;

    always_comb begin
        w_dimmed = i_cfg.dim_enable
                && (i_cfg.focus_layer_id != $signed(FOCUS_NONE))
                && ({1'b0, i_data.layer_id} != i_cfg.focus_layer_id);
        priority if (i_data.cur_alpha == CH_MAX) begin
            n_a_mode = MODE_PASS;
        end else if (i_data.cur_alpha == '0) begin
            n_a_mode = MODE_COPY;
        end else if (i_data.action == ACT_UNDER) begin
            n_a_mode = MODE_BLEND;
        end else begin
            n_a_mode = MODE_FLAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_mode   <= n_a_mode;
            r_a_half   <= (i_data.action == ACT_UNDER) && w_dimmed;
            r_a_dimmed <= w_dimmed;
            r_a_alpha  <= i_data.cur_alpha;
            r_a_wl     <= i_data.src_alpha * w_inv;
            r_a_cur    <= w_cur;
            r_a_src    <= w_src;
        end
    end

    // ---- stage B ----
    assign w_b_inv = CH_MAX - r_a_alpha;
    assign w_wc    = {r_a_alpha, 9'b0} - W_W'({r_a_alpha, 1'b0});  // 510*a
    assign w_wl    = r_a_dimmed ? {1'b0, r_a_wl} : {r_a_wl, 1'b0};
    assign w_den   = DEN_W'(w_wc) + DEN_W'(w_wl);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_w1[k]   = W_W'(1);
            w_x1[k]   = r_a_cur[k];
            w_w2[k]   = '0;
            w_x2[k]   = '0;
            n_b_dv[k] = DIV_ONE;
            unique case (r_a_mode)
                MODE_PASS: begin
                    w_x1[k] = r_a_cur[k];
                end
                MODE_COPY: begin
                    w_x1[k] = (k == CH_ALPHA && r_a_half) ? (r_a_src[k] >> 1) : r_a_src[k];
                end
                MODE_BLEND: begin
                    w_w1[k] = w_wc;
                    w_w2[k] = w_wl;
                    if (k == CH_ALPHA) begin
                        // alpha = den / 510
                        w_x1[k]   = CH_W'(1);
                        w_x2[k]   = CH_W'(1);
                        n_b_dv[k] = DIV_ALPHA;
                    end else begin
                        w_x1[k]   = r_a_cur[k];
                        w_x2[k]   = r_a_src[k];
                        n_b_dv[k] = w_den;
                    end
                end
                MODE_FLAT: begin
                    n_b_dv[k] = DIV_FLAT;
                    if (k == CH_ALPHA) begin
                        // 255*255/255 gives an opaque result
                        w_w1[k] = W_W'(CH_MAX);
                        w_x1[k] = CH_MAX;
                    end else begin
                        w_w1[k] = W_W'(r_a_alpha);
                        w_x1[k] = r_a_cur[k];
                        w_w2[k] = W_W'(w_b_inv);
                        w_x2[k] = r_a_src[k];
                    end
                end
                default: begin
                    w_x1[k] = r_a_cur[k];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_a_valid) begin
            for (int k = 0; k < LANES; k++) begin
                r_b_p1[k] <= PROD_W'(w_w1[k]) * PROD_W'(w_x1[k]);
                r_b_p2[k] <= PROD_W'(w_w2[k]) * PROD_W'(w_x2[k]);
                r_b_dv[k] <= n_b_dv[k];
            end
        end
    end

    // ---- stage C ----
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_sum[k]         = {1'b0, r_b_p1[k]} + {1'b0, r_b_p2[k]};
            n_c_data[k].rem  = w_sum[k][REM_W-1:0];
            n_c_data[k].dv   = {r_b_dv[k], {(Q_W-1){1'b0}}};
            n_c_data[k].q    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready && r_b_valid) begin
            r_c_data <= n_c_data;
        end
    end

    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_dv[0] != '0 && r_b_dv[1] != '0 && r_b_dv[2] != '0
                       && r_b_dv[3] != '0))
        else $error("zero divisor entered the divider");

endmodule

/* hw/rtl/lac_cell.sv */
// ----------------------------------------------------------------------------
// lac_cell: one restoring-division step on four lanes
// Resolves one quotient bit per lane, then halves the divisor for the
// next cell in the row.
// ----------------------------------------------------------------------------
module lac_cell import lac_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_lanes i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_lanes o_data
);

    logic             r_valid;
    t_lanes           r_data;
    t_lanes           n_data;
    logic [LANES-1:0] w_ge;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_ge[k]        = i_data[k].rem >= i_data[k].dv;
            n_data[k].rem  = w_ge[k] ? (i_data[k].rem - i_data[k].dv) : i_data[k].rem;
            n_data[k].dv   = i_data[k].dv >> 1;
            n_data[k].q    = {i_data[k].q[Q_W-2:0], w_ge[k]};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // remainder must end below the divisor it was tested against
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=>
            (r_data[0].rem < $past(i_data[0].dv) && r_data[1].rem < $past(i_data[1].dv)
             && r_data[2].rem < $past(i_data[2].dv)
             && r_data[3].rem < $past(i_data[3].dv)))
        else $error("divider remainder out of range");

endmodule

/* hw/rtl/layer_alpha_compositor.sv */
// ----------------------------------------------------------------------------
// layer_alpha_compositor: RGBA8 under/flatten compositor
//
//   port group   dir   handshake            beat
//   i_in_*       in    i_in_valid/o_in_ready   t_in_item (canvas + source)
//   o_out_*      out   o_out_valid/i_out_ready t_out_item (new canvas pixel)
//   APB          in    psel/penable/pready     reg 0 dim_enable, reg 1 focus id
//
// One beat per clock while the output is not stalled. The pipe is 3 front
// stages, then a row of 8 division cells, one quotient bit each; the last
// cell is the output register. Reset clears all stage valids and sets the
// registers to dim off, focus none. A stalled output holds its beat; empty
// stages upstream keep filling, so input stalls only once the pipe is full.
// ----------------------------------------------------------------------------
module layer_alpha_compositor import lac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg           w_cfg;
    t_lanes         w_lanes [Q_W+1];
    logic [Q_W:0]   w_valid;
    logic [Q_W:0]   w_ready;

    lac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_lanes[0])
    );

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        lac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_lanes[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_lanes[g+1])
        );
    end

    assign w_ready[Q_W]         = i_out_ready;
    assign o_out_valid          = w_valid[Q_W];
    assign o_out_data.out_red   = w_lanes[Q_W][0].q;
    assign o_out_data.out_green = w_lanes[Q_W][1].q;
    assign o_out_data.out_blue  = w_lanes[Q_W][2].q;
    assign o_out_data.out_alpha = w_lanes[Q_W][CH_ALPHA].q;

    // with the output register empty nothing upstream can be blocked
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output is empty");

endmodule
